// ===== hdl/xdvm_pkg.sv =====
// Shared constants, widths and tables of the X-drive wheel velocity mixer.
package xdvm_pkg;

	localparam int SPEED_BITS_DEF    = 16;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_LEN          = 24;

	localparam int HEAD_W = 17;
	localparam int SPD_W  = 16;
	localparam int RATE_W = 16;
	localparam int LIM_W  = 15;
	localparam int RAD_W  = 16;
	localparam int CFG_W  = 16;

	// register indexes of the configuration port
	localparam logic CFG_MAX_SPEED   = 1'b0;
	localparam logic CFG_TURN_RADIUS = 1'b1;

	localparam logic [LIM_W-1:0] MAX_SPEED_RST   = 15'd25600;
	localparam logic [RAD_W-1:0] TURN_RADIUS_RST = 16'd256;

	// angle handling, hundredths of a degree
	localparam int ANG_BIAS = 153000;   // 90 degrees plus four turns, keeps the sum positive
	localparam int ANG_4T   = 144000;
	localparam int ANG_2T   = 72000;
	localparam int ANG_1T   = 36000;
	localparam int ANG_HALF = 18000;
	localparam int ANG_QTR  = 9000;

	localparam int CORDIC_X0  = 652032875;   // gain-compensated 1.0, Q2.30
	localparam int TWO_PI_Q28 = 1686629713;

	function automatic int atan_val(input int idx);
		int v;
		case (idx)
			0:  v = 294912000;
			1:  v = 174096719;
			2:  v = 91987925;
			3:  v = 46694507;
			4:  v = 23437865;
			5:  v = 11730358;
			6:  v = 5866610;
			7:  v = 2933484;
			8:  v = 1466764;
			9:  v = 733385;
			10: v = 366693;
			11: v = 183346;
			12: v = 91673;
			13: v = 45837;
			14: v = 22918;
			15: v = 11459;
			16: v = 5730;
			17: v = 2865;
			18: v = 1432;
			19: v = 716;
			20: v = 358;
			21: v = 179;
			22: v = 90;
			23: v = 45;
			default: v = 0;
		endcase
		return v;
	endfunction

endpackage

// ===== hdl/xdrive_wheel_velocity_mixer.sv =====
// X-drive wheel velocity mixer: pipelined CORDIC, mixing and normalising divider.
//
// Usage: raise start for one cycle with a command word on target_heading,
// current_heading, linear_speed and turn_rate; the word is taken at that edge
// (busy never rises, so a new command may follow in every cycle). When the
// word reaches the output register, done is high for one cycle with the four
// wheel speeds; commands come out in the order they went in, one per cycle.
// Stages: heading sum, angle reduction and rotation product, one CORDIC
// iteration per stage, speed multiply, wheel sums, peak magnitude, numerator
// and limit test, one quotient bit per stage over fifteen stages, then
// sign, select and saturation. The divider and the CORDIC set the latency;
// throughput is one word per cycle.
// The receiver cannot stall, so nothing is ever held back inside.
// Configuration (wr_en, wr_idx, wr_data) writes max_wheel_speed (index 0)
// or turn_radius (index 1); write only while no command is in flight.
// Reset clears all valid bits and restores the register defaults
// (limit 100.0, radius 1.0); no clearing pass is needed.
module xdrive_wheel_velocity_mixer
	import xdvm_pkg::*;
#(
	parameter int SPEED_BITS    = SPEED_BITS_DEF,
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [HEAD_W-1:0]     target_heading,
	input  logic signed [HEAD_W-1:0]     current_heading,
	input  logic signed [SPD_W-1:0]      linear_speed,
	input  logic signed [RATE_W-1:0]     turn_rate,
	input  logic                         wr_en,
	input  logic                         wr_idx,
	input  logic        [CFG_W-1:0]      wr_data,
	output logic                         done,
	output logic signed [SPEED_BITS-1:0] front_left_speed,
	output logic signed [SPEED_BITS-1:0] back_left_speed,
	output logic signed [SPEED_BITS-1:0] front_right_speed,
	output logic signed [SPEED_BITS-1:0] back_right_speed
);

	localparam int CS = CORDIC_STAGES;
	localparam int XW = 33;                 // CORDIC x and y
	localparam int ZW = 32;                 // CORDIC residual angle
	localparam int PW = 50;                 // component product
	localparam int VW = PW - 14;            // vx, vy
	localparam int RW = 40;                 // rotation term
	localparam int WW = 42;                 // wheel sums
	localparam int MW = 41;                 // magnitudes
	localparam int NW = MW + LIM_W + 1;     // divider remainder
	localparam int QW = LIM_W;              // quotient bits
	localparam int DW = WW - 16;            // rounded value
	localparam int CW = 33;                 // saturation compare

	localparam logic signed [CW-1:0] OUT_HI = (CW'(1) <<< (SPEED_BITS - 1)) - CW'(1);
	localparam logic signed [CW-1:0] OUT_LO = -OUT_HI - CW'(1);

	// Saturate to the output word width.
	function automatic logic [SPEED_BITS-1:0] sat(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] r;
		if (v > OUT_HI) r = OUT_HI;
		else if (v < OUT_LO) r = OUT_LO;
		else r = v;
		return r[SPEED_BITS-1:0];
	endfunction

	// The pipeline always advances, so a command is never refused.
	assign busy = 1'b0;

	// ---------------- configuration registers ----------------
	logic [LIM_W-1:0] lim_q;
	logic [RAD_W-1:0] rad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= MAX_SPEED_RST;
			rad_q <= TURN_RADIUS_RST;
		end else if (wr_en) begin
			unique case (wr_idx)
				CFG_MAX_SPEED:   lim_q <= wr_data[LIM_W-1:0];
				CFG_TURN_RADIUS: rad_q <= wr_data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- stage 1: heading sum, rate times radius ----------------
	logic signed [19:0] ang_c;
	logic signed [32:0] rr_c;
	logic               vld_s1;
	logic [18:0]        ang_s1;
	logic signed [SPD_W-1:0] spd_s1;
	logic signed [32:0] rr_s1;

	assign ang_c = 20'(ANG_BIAS) - 20'(target_heading) + 20'(current_heading);
	assign rr_c  = 33'(turn_rate) * $signed({17'b0, rad_q});

	always_ff @(posedge clk) begin
		ang_s1 <= ang_c[18:0];
		spd_s1 <= linear_speed;
		rr_s1  <= rr_c;
	end

	// ---------------- stage 2: angle reduction, rotation term ----------------
	logic [18:0]        r1_c, r2_c, r3_c;
	logic signed [17:0] af0_c, af1_c;
	logic               neg_c;
	logic signed [63:0] rp_c;

	always_comb begin
		r1_c = (ang_s1 >= 19'(ANG_4T)) ? ang_s1 - 19'(ANG_4T) : ang_s1;
		r2_c = (r1_c >= 19'(ANG_2T)) ? r1_c - 19'(ANG_2T) : r1_c;
		r3_c = (r2_c >= 19'(ANG_1T)) ? r2_c - 19'(ANG_1T) : r2_c;
		af0_c = $signed({1'b0, r3_c[16:0]});
		if (af0_c > 18'sd18000) af0_c = af0_c - 18'(ANG_1T);
		// fold into the right half plane, flip the result afterwards
		neg_c = 1'b0;
		af1_c = af0_c;
		if (af0_c > 18'(ANG_QTR)) begin
			af1_c = af0_c - 18'(ANG_HALF);
			neg_c = 1'b1;
		end else if (af0_c < -18'(ANG_QTR)) begin
			af1_c = af0_c + 18'(ANG_HALF);
			neg_c = 1'b1;
		end
	end

	assign rp_c = 64'(rr_s1) * 64'(TWO_PI_Q28);

	logic signed [XW-1:0] cx_s   [0:CS];
	logic signed [XW-1:0] cy_s   [0:CS];
	logic signed [ZW-1:0] cz_s   [0:CS];
	logic signed [16:0]   cspd_s [0:CS];
	logic signed [RW-1:0] crot_s [0:CS];
	logic                 cvld_s [0:CS];

	always_ff @(posedge clk) begin
		cx_s[0]   <= XW'(CORDIC_X0);
		cy_s[0]   <= '0;
		cz_s[0]   <= ZW'(af1_c) <<< 16;
		// negating the speed stands in for negating cosine and sine
		cspd_s[0] <= neg_c ? -17'(spd_s1) : 17'(spd_s1);
		crot_s[0] <= rp_c[63:24];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			cvld_s[0] <= 1'b0;
		end else begin
			vld_s1    <= start;
			cvld_s[0] <= vld_s1;
		end
	end

	// ---------------- CORDIC, one iteration per stage ----------------
	genvar gi;
	for (gi = 0; gi < CS; gi++) begin : g_cordic
		localparam logic signed [ZW-1:0] ATAN = ZW'(atan_val(gi));
		logic signed [XW-1:0] dx, dy;
		assign dx = cy_s[gi] >>> gi;
		assign dy = cx_s[gi] >>> gi;

		always_ff @(posedge clk) begin
			if (!cz_s[gi][ZW-1]) begin
				cx_s[gi+1] <= cx_s[gi] - dx;
				cy_s[gi+1] <= cy_s[gi] + dy;
				cz_s[gi+1] <= cz_s[gi] - ATAN;
			end else begin
				cx_s[gi+1] <= cx_s[gi] + dx;
				cy_s[gi+1] <= cy_s[gi] - dy;
				cz_s[gi+1] <= cz_s[gi] + ATAN;
			end
			cspd_s[gi+1] <= cspd_s[gi];
			crot_s[gi+1] <= crot_s[gi];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) cvld_s[gi+1] <= 1'b0;
			else         cvld_s[gi+1] <= cvld_s[gi];
		end
	end

	// ---------------- stage 3: speed components ----------------
	logic signed [PW-1:0] px_c, py_c;
	logic signed [VW-1:0] vx_s3, vy_s3;
	logic signed [RW-1:0] rot_s3;
	logic                 vld_s3;

	assign px_c = PW'(cx_s[CS]) * PW'(cspd_s[CS]);
	assign py_c = PW'(cy_s[CS]) * PW'(cspd_s[CS]);

	always_ff @(posedge clk) begin
		vx_s3  <= px_c[PW-1:14];
		vy_s3  <= py_c[PW-1:14];
		rot_s3 <= crot_s[CS];
	end

	// ---------------- stage 4: wheel sums ----------------
	// front left equals back right, back left equals front right
	logic signed [WW-1:0] w0_s4, w1_s4;
	logic                 vld_s4;

	always_ff @(posedge clk) begin
		w0_s4 <= WW'(vy_s3) + WW'(vx_s3) + WW'(rot_s3);
		w1_s4 <= WW'(vy_s3) - WW'(vx_s3) - WW'(rot_s3);
	end

	// ---------------- stage 5: magnitudes, peak, rounding ----------------
	logic signed [WW-1:0] a0_c, a1_c, rw0_c, rw1_c;
	logic [MW-1:0]        mag0_s5, mag1_s5, m_s5;
	logic                 sgn0_s5, sgn1_s5, vld_s5;
	logic signed [DW-1:0] rnd0_s5, rnd1_s5;

	assign a0_c  = w0_s4[WW-1] ? -w0_s4 : w0_s4;
	assign a1_c  = w1_s4[WW-1] ? -w1_s4 : w1_s4;
	assign rw0_c = w0_s4 + WW'(32768);
	assign rw1_c = w1_s4 + WW'(32768);

	always_ff @(posedge clk) begin
		mag0_s5 <= a0_c[MW-1:0];
		mag1_s5 <= a1_c[MW-1:0];
		m_s5    <= (a0_c[MW-1:0] > a1_c[MW-1:0]) ? a0_c[MW-1:0] : a1_c[MW-1:0];
		sgn0_s5 <= w0_s4[WW-1];
		sgn1_s5 <= w1_s4[WW-1];
		rnd0_s5 <= rw0_c[WW-1:16];
		rnd1_s5 <= rw1_c[WW-1:16];
	end

	// ---------------- stage 6: numerators, limit test ----------------
	logic [NW-1:0]         rem0_sd [0:QW];
	logic [NW-1:0]         rem1_sd [0:QW];
	logic [QW-1:0]         q0_sd   [0:QW];
	logic [QW-1:0]         q1_sd   [0:QW];
	logic [MW-1:0]         m_sd    [0:QW];
	logic                  big_sd  [0:QW];
	logic                  sgn0_sd [0:QW];
	logic                  sgn1_sd [0:QW];
	logic [SPEED_BITS-1:0] rnd0_sd [0:QW];
	logic [SPEED_BITS-1:0] rnd1_sd [0:QW];
	logic                  vld_sd  [0:QW];

	always_ff @(posedge clk) begin
		rem0_sd[0] <= NW'(mag0_s5) * NW'(lim_q);
		rem1_sd[0] <= NW'(mag1_s5) * NW'(lim_q);
		q0_sd[0]   <= '0;
		q1_sd[0]   <= '0;
		m_sd[0]    <= m_s5;
		big_sd[0]  <= m_s5 > {10'b0, lim_q, 16'b0};
		sgn0_sd[0] <= sgn0_s5;
		sgn1_sd[0] <= sgn1_s5;
		rnd0_sd[0] <= sat(CW'(rnd0_s5));
		rnd1_sd[0] <= sat(CW'(rnd1_s5));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_sd[0] <= 1'b0;
		end else begin
			vld_s3    <= cvld_s[CS];
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_sd[0] <= vld_s5;
		end
	end

	// ---------------- divider, one quotient bit per stage ----------------
	// Magnitude never exceeds the peak, so the quotient fits the limit width.
	genvar gj;
	for (gj = 0; gj < QW; gj++) begin : g_div
		logic [NW-1:0] sub;
		logic          ge0, ge1;
		assign sub = NW'(m_sd[gj]) << (QW - 1 - gj);
		assign ge0 = rem0_sd[gj] >= sub;
		assign ge1 = rem1_sd[gj] >= sub;

		always_ff @(posedge clk) begin
			rem0_sd[gj+1] <= ge0 ? rem0_sd[gj] - sub : rem0_sd[gj];
			rem1_sd[gj+1] <= ge1 ? rem1_sd[gj] - sub : rem1_sd[gj];
			q0_sd[gj+1]   <= {q0_sd[gj][QW-2:0], ge0};
			q1_sd[gj+1]   <= {q1_sd[gj][QW-2:0], ge1};
			m_sd[gj+1]    <= m_sd[gj];
			big_sd[gj+1]  <= big_sd[gj];
			sgn0_sd[gj+1] <= sgn0_sd[gj];
			sgn1_sd[gj+1] <= sgn1_sd[gj];
			rnd0_sd[gj+1] <= rnd0_sd[gj];
			rnd1_sd[gj+1] <= rnd1_sd[gj];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_sd[gj+1] <= 1'b0;
			else         vld_sd[gj+1] <= vld_sd[gj];
		end
	end

	// ---------------- output stage: sign, select, saturate ----------------
	logic signed [CW-1:0]  qs0_c, qs1_c;
	logic [SPEED_BITS-1:0] res0_c, res1_c;
	logic [SPEED_BITS-1:0] w0_q, w1_q;
	logic                  done_q;

	assign qs0_c  = sgn0_sd[QW] ? -CW'(q0_sd[QW]) : CW'(q0_sd[QW]);
	assign qs1_c  = sgn1_sd[QW] ? -CW'(q1_sd[QW]) : CW'(q1_sd[QW]);
	assign res0_c = big_sd[QW] ? sat(qs0_c) : rnd0_sd[QW];
	assign res1_c = big_sd[QW] ? sat(qs1_c) : rnd1_sd[QW];

	always_ff @(posedge clk) begin
		w0_q <= res0_c;
		w1_q <= res1_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= vld_sd[QW];
	end

	assign done              = done_q;
	assign front_left_speed  = w0_q;
	assign back_right_speed  = w0_q;
	assign back_left_speed   = w1_q;
	assign front_right_speed = w1_q;

endmodule
